### design/wstc_pkg.sv
// Shared types and constants for the wall-clock to timecode converter.
package wstc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_UTC_OFFSET = 2'd0;
    localparam logic [1:0] CFG_FRAME_RATE = 2'd1;
    localparam logic [1:0] CFG_DROP_FRAME = 2'd2;
    localparam logic [1:0] CFG_ENABLE     = 2'd3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int EPOCH_W     = 32;
    localparam int MICRO_W     = 20;
    localparam int TIME_W      = 33;
    localparam int PROD_W      = 25;
    localparam int FRAME_W     = 5;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SEC_W       = 6;
    localparam int DAY_SEC_W   = 17;
    localparam int MIN_OF_DAY_W = 11;

    localparam logic [MICRO_W-1:0] MICRO_MAX       = 20'd999999;
    localparam logic [FRAME_W-1:0] FRAME_RATE_RST  = 5'd25;
    localparam logic [FRAME_W-1:0] DROP_FRAME_NUM  = 5'd2;

    // Seconds of the day: t mod 86400 = ((t >> 7) mod 675) * 128 + t[6:0].
    localparam int            LOW_SEC_BITS = 7;
    localparam int            DIV675_SHIFT = 36;
    localparam logic [26:0]   RECIP_675    = 27'd101806633;
    localparam logic [9:0]    DIV_675      = 10'd675;

    // Frames: (micro * rate) / 1000000 by exact reciprocal.
    localparam int            MEGA_SHIFT   = 45;
    localparam logic [25:0]   RECIP_MEGA   = 26'd35184373;

    // Divide by 60 as (v >> 2) / 15, with reciprocals sized for each operand range.
    localparam int            DIV15_SHIFT_A = 19;
    localparam logic [15:0]   RECIP_15_A    = 16'd34953;
    localparam int            DIV15_SHIFT_B = 13;
    localparam logic [9:0]    RECIP_15_B    = 10'd547;
    localparam logic [5:0]    SIXTY         = 6'd60;

    // Number of pipeline stages inside the time-of-day datapath
    localparam int HMS_STAGES = 5;

    typedef logic [HMS_STAGES-1:0] t_stage_en;

    // Per-beat control that travels alongside the datapath
    typedef struct packed {
        logic en;     // converter was enabled for this beat
        logic chg;    // seconds differ from the last value seen
        logic avail;  // new second began at zero microseconds
    } t_side;

endpackage

### design/wstc_hms_pipe.sv
// Pipelined split of the offset seconds into hours, minutes and seconds, plus frame number.
module wstc_hms_pipe (
    input  logic                                i_clk,
    input  wstc_pkg::t_stage_en                 i_ld,
    input  logic [wstc_pkg::TIME_W-1:0]         i_time,
    input  logic [wstc_pkg::PROD_W-1:0]         i_prod,
    input  wstc_pkg::t_side                     i_side,
    output logic [wstc_pkg::HOUR_W-1:0]         o_hours,
    output logic [wstc_pkg::MIN_W-1:0]          o_minutes,
    output logic [wstc_pkg::SEC_W-1:0]          o_seconds,
    output logic [wstc_pkg::FRAME_W-1:0]        o_frames,
    output wstc_pkg::t_side                     o_side
);

    // Stage 2: quotient by 675 and the frame number
    logic [25:0]                         r2_x;
    logic [16:0]                         r2_q;
    logic [wstc_pkg::LOW_SEC_BITS-1:0]   r2_lo;
    logic [wstc_pkg::FRAME_W-1:0]        r2_fq;
    wstc_pkg::t_side                     r2_side;

    // Stage 3: seconds of the day
    logic [wstc_pkg::DAY_SEC_W-1:0]      r3_d;
    logic [wstc_pkg::FRAME_W-1:0]        r3_fq;
    wstc_pkg::t_side                     r3_side;

    // Stage 4: minutes of the day
    logic [wstc_pkg::DAY_SEC_W-1:0]      r4_d;
    logic [wstc_pkg::MIN_OF_DAY_W-1:0]   r4_q60;
    logic [wstc_pkg::FRAME_W-1:0]        r4_fq;
    wstc_pkg::t_side                     r4_side;

    // Stage 5: seconds and hours
    logic [wstc_pkg::MIN_OF_DAY_W-1:0]   r5_q60;
    logic [wstc_pkg::SEC_W-1:0]          r5_sec;
    logic [wstc_pkg::HOUR_W-1:0]         r5_hrs;
    logic [wstc_pkg::FRAME_W-1:0]        r5_fq;
    wstc_pkg::t_side                     r5_side;

    // Stage 6: minutes
    logic [wstc_pkg::MIN_W-1:0]          r6_min;
    logic [wstc_pkg::SEC_W-1:0]          r6_sec;
    logic [wstc_pkg::HOUR_W-1:0]         r6_hrs;
    logic [wstc_pkg::FRAME_W-1:0]        r6_fq;
    wstc_pkg::t_side                     r6_side;

    logic [25:0]                         s2_x;
    logic [52:0]                         s2_m675;
    logic [50:0]                         s2_mfr;
    logic [26:0]                         s3_qm;
    logic [25:0]                         s3_r;
    logic [30:0]                         s4_m60;
    logic [16:0]                         s5_sm;
    logic [16:0]                         s5_sec;
    logic [18:0]                         s5_mh;
    logic [10:0]                         s6_hm;
    logic [10:0]                         s6_min;

    always_comb begin
        s2_x    = i_time[wstc_pkg::TIME_W-1:wstc_pkg::LOW_SEC_BITS];
        s2_m675 = 53'(s2_x) * 53'(wstc_pkg::RECIP_675);
        s2_mfr  = 51'(i_prod) * 51'(wstc_pkg::RECIP_MEGA);

        s3_qm   = 27'(r2_q) * 27'(wstc_pkg::DIV_675);
        s3_r    = r2_x - s3_qm[25:0];

        s4_m60  = 31'(r3_d[16:2]) * 31'(wstc_pkg::RECIP_15_A);

        s5_sm   = 17'(r4_q60) * 17'(wstc_pkg::SIXTY);
        s5_sec  = r4_d - s5_sm;
        s5_mh   = 19'(r4_q60[10:2]) * 19'(wstc_pkg::RECIP_15_B);

        s6_hm   = 11'(r5_hrs) * 11'(wstc_pkg::SIXTY);
        s6_min  = r5_q60 - s6_hm;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r2_x    <= s2_x;
            r2_q    <= s2_m675[wstc_pkg::DIV675_SHIFT +: 17];
            r2_lo   <= i_time[wstc_pkg::LOW_SEC_BITS-1:0];
            r2_fq   <= s2_mfr[wstc_pkg::MEGA_SHIFT +: wstc_pkg::FRAME_W];
            r2_side <= i_side;
        end
        if (i_ld[1]) begin
            // The remainder by 675 is below 1024, so ten bits carry it.
            r3_d    <= {s3_r[9:0], r2_lo};
            r3_fq   <= r2_fq;
            r3_side <= r2_side;
        end
        if (i_ld[2]) begin
            r4_d    <= r3_d;
            r4_q60  <= s4_m60[wstc_pkg::DIV15_SHIFT_A +: wstc_pkg::MIN_OF_DAY_W];
            r4_fq   <= r3_fq;
            r4_side <= r3_side;
        end
        if (i_ld[3]) begin
            r5_q60  <= r4_q60;
            r5_sec  <= s5_sec[wstc_pkg::SEC_W-1:0];
            r5_hrs  <= s5_mh[wstc_pkg::DIV15_SHIFT_B +: wstc_pkg::HOUR_W];
            r5_fq   <= r4_fq;
            r5_side <= r4_side;
        end
        if (i_ld[4]) begin
            r6_min  <= s6_min[wstc_pkg::MIN_W-1:0];
            r6_sec  <= r5_sec;
            r6_hrs  <= r5_hrs;
            r6_fq   <= r5_fq;
            r6_side <= r5_side;
        end
    end

    assign o_hours   = r6_hrs;
    assign o_minutes = r6_min;
    assign o_seconds = r6_sec;
    assign o_frames  = r6_fq;
    assign o_side    = r6_side;

endmodule

### design/wallclock_to_smpte_timecode.sv
// Top level of the wall-clock to timecode converter: handshake, offset stage and timecode state.
//
// Input beats carry whole epoch seconds and microseconds on a valid/stall channel; each
// accepted beat yields exactly one result beat, in order, on the output valid/stall channel.
// A result holds the stored hours, minutes, seconds and frame after that sample, plus a flag
// for a second that began at exactly zero microseconds.
// The datapath is an eight-register pipeline (input register, offset stage, five stages of
// constant-reciprocal division, output register). Each beat passes through these registers
// in order, and one beat per cycle is sustained while the receiver does not stall.
// The timecode state is updated only as each beat enters the output register, so the
// drop-frame test always sees the state left by the previous beat.
// When the receiver stalls, the finished result holds on the outputs while the earlier
// stages keep filling; input stall rises only once every stage holds a beat.
// Reset clears the pipeline, the timecode state and the configuration (offset 0, 25 frames
// per second, drop-frame and enable off). Configuration is written through a plain write
// port and must only change while no beat is in flight.
module wallclock_to_smpte_timecode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wstc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wstc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [wstc_pkg::EPOCH_W-1:0]        i_epoch_seconds,
    input  logic [wstc_pkg::MICRO_W-1:0]        i_micro_seconds,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [wstc_pkg::HOUR_W-1:0]         o_hours,
    output logic [wstc_pkg::MIN_W-1:0]          o_minutes,
    output logic [wstc_pkg::SEC_W-1:0]          o_seconds_out,
    output logic [wstc_pkg::FRAME_W-1:0]        o_frames,
    output logic                                o_timecode_available
);

    localparam int NSTG = wstc_pkg::HMS_STAGES + 2;

    // Configuration
    logic signed [wstc_pkg::CFG_DATA_W-1:0] r_utc_offset;
    logic [wstc_pkg::FRAME_W-1:0]           r_frame_rate;
    logic                                   r_drop_frame;
    logic                                   r_enable;

    // Pipeline control
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  n_vld;
    logic [NSTG:0]    rdy;
    logic             r_ovalid;
    logic             commit;

    // Input and offset stage payload
    logic [wstc_pkg::EPOCH_W-1:0]  r0_epoch;
    logic [wstc_pkg::MICRO_W-1:0]  r0_micro;
    logic [wstc_pkg::TIME_W-1:0]   r1_time;
    logic [wstc_pkg::PROD_W-1:0]   r1_prod;
    wstc_pkg::t_side               r1_side;

    // Timecode state
    logic [wstc_pkg::TIME_W-1:0]   r_last;
    logic [wstc_pkg::HOUR_W-1:0]   r_hour;
    logic [wstc_pkg::MIN_W-1:0]    r_min;
    logic [wstc_pkg::SEC_W-1:0]    r_sec;
    logic [wstc_pkg::FRAME_W-1:0]  r_frame;
    logic                          r_avail;

    logic signed [wstc_pkg::TIME_W:0]  s1_sum;
    logic [wstc_pkg::TIME_W-1:0]       n_time;
    logic [wstc_pkg::MICRO_W-1:0]      s1_um;
    logic [wstc_pkg::PROD_W-1:0]       n_prod;
    wstc_pkg::t_side                   n_side;

    wstc_pkg::t_stage_en               hms_ld;
    logic [wstc_pkg::HOUR_W-1:0]       p_hours;
    logic [wstc_pkg::MIN_W-1:0]        p_minutes;
    logic [wstc_pkg::SEC_W-1:0]        p_seconds;
    logic [wstc_pkg::FRAME_W-1:0]      p_frames;
    wstc_pkg::t_side                   p_side;
    logic [wstc_pkg::FRAME_W-1:0]      n_frame;
    logic                              drop_slot;

    // A stage can take a beat when it is empty or its beat moves on this cycle.
    always_comb begin
        rdy[NSTG] = !r_ovalid || !i_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
        for (int k = 0; k < wstc_pkg::HMS_STAGES; k++) begin
            hms_ld[k] = rdy[k+2] && r_vld[k+1];
        end
        commit = r_vld[NSTG-1] && rdy[NSTG];
    end

    assign o_stall = !rdy[0];

    // Offset stage: saturating offset add, change detect and the frame product.
    always_comb begin
        s1_sum = $signed({2'b00, r0_epoch})
               + $signed({{(wstc_pkg::TIME_W + 1 - wstc_pkg::CFG_DATA_W){r_utc_offset[16]}},
                          r_utc_offset});
        n_time = s1_sum[wstc_pkg::TIME_W] ? '0 : s1_sum[wstc_pkg::TIME_W-1:0];
        s1_um  = (r0_micro > wstc_pkg::MICRO_MAX) ? wstc_pkg::MICRO_MAX : r0_micro;
        n_prod = {5'd0, s1_um} * {20'd0, r_frame_rate};
        n_side.en    = r_enable;
        n_side.chg   = r_enable && (n_time != r_last);
        n_side.avail = n_side.chg && (r0_micro == '0);
    end

    wstc_hms_pipe u_hms (
        .i_clk     (i_clk),
        .i_ld      (hms_ld),
        .i_time    (r1_time),
        .i_prod    (r1_prod),
        .i_side    (r1_side),
        .o_hours   (p_hours),
        .o_minutes (p_minutes),
        .o_seconds (p_seconds),
        .o_frames  (p_frames),
        .o_side    (p_side)
    );

    // Drop-frame looks at the minute and second left by the previous sample.
    always_comb begin
        drop_slot = r_drop_frame && (r_sec == '0)
                 && !(r_min inside {6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50});
        n_frame   = (drop_slot && (p_frames < wstc_pkg::DROP_FRAME_NUM))
                  ? wstc_pkg::DROP_FRAME_NUM : p_frames;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utc_offset <= '0;
            r_frame_rate <= wstc_pkg::FRAME_RATE_RST;
            r_drop_frame <= 1'b0;
            r_enable     <= 1'b0;
            r_vld        <= '0;
            r_ovalid     <= 1'b0;
            r_last       <= '0;
            r_hour       <= '0;
            r_min        <= '0;
            r_sec        <= '0;
            r_frame      <= '0;
            r_avail      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wstc_pkg::CFG_UTC_OFFSET: r_utc_offset <= $signed(i_cfg_data);
                    wstc_pkg::CFG_FRAME_RATE: r_frame_rate <= i_cfg_data[wstc_pkg::FRAME_W-1:0];
                    wstc_pkg::CFG_DROP_FRAME: r_drop_frame <= i_cfg_data[0];
                    wstc_pkg::CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_vld    <= n_vld;
            r_ovalid <= rdy[NSTG] ? r_vld[NSTG-1] : r_ovalid;
            if (rdy[1] && r_vld[0] && r_enable) begin
                r_last <= n_time;
            end
            if (commit) begin
                r_avail <= p_side.avail;
                if (p_side.en) begin
                    r_frame <= n_frame;
                end
                if (p_side.chg) begin
                    r_hour <= p_hours;
                    r_min  <= p_minutes;
                    r_sec  <= p_seconds;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r0_epoch <= i_epoch_seconds;
            r0_micro <= i_micro_seconds;
        end
        if (rdy[1] && r_vld[0]) begin
            r1_time <= n_time;
            r1_prod <= n_prod;
            r1_side <= n_side;
        end
    end

    assign o_valid              = r_ovalid;
    assign o_hours              = r_hour;
    assign o_minutes            = r_min;
    assign o_seconds_out        = r_sec;
    assign o_frames             = r_frame;
    assign o_timecode_available = r_avail;

endmodule
